// ----- sv/ptpt_pkg.sv -----
// ----------------------------------------------------------------------------
// ptpt_pkg
// Types and constants shared by the page transition probability table.
// ----------------------------------------------------------------------------
package ptpt_pkg;

   // Fraction bits of the Q1.16 probability.
   localparam int unsigned Q_BITS = 16;
   localparam int unsigned PROB_W = Q_BITS + 1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACC,
      ST_TRN,
      ST_ROW,
      ST_DRAIN
   } st_type;

   typedef enum logic [1:0] {
      PK_RATIO,
      PK_ZERO,
      PK_ONE
   } prob_kind_type;

endpackage

// ----- sv/ptpt_ram.sv -----
// ----------------------------------------------------------------------------
// ptpt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ptpt_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/page_transition_probability_table.sv -----
// ----------------------------------------------------------------------------
// page_transition_probability_table
// Counts page accesses and page-to-page transitions per process and reports
// the outgoing transition probabilities of the accessed page.
// ----------------------------------------------------------------------------
// Flow: an accepted input transaction passes through ST_ACC and ST_TRN, then
// ST_ROW reads one transition counter per cycle while the output does not
// stall, feeding a 16-stage divider pipeline; ST_DRAIN waits for the last entry.
// Reset: history bits clear at once; a clearing pass over all
// NUM_PROCESSES * NUM_PAGES * NUM_PAGES transition counter addresses then
// zeroes both counter RAMs, during which no input transaction is taken.
module page_transition_probability_table #(
   parameter int unsigned NUM_PROCESSES = 32,
   parameter int unsigned NUM_PAGES     = 32,
   parameter int unsigned COUNT_BITS    = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [4:0]  req_process_id,
   input  logic [4:0]  req_page,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_owner_process,
   output logic [4:0]  rsp_from_page,
   output logic [4:0]  rsp_to_page,
   output logic [16:0] rsp_probability,
   output logic        rsp_last
);
   import ptpt_pkg::*;

   localparam int unsigned CB     = COUNT_BITS;
   localparam int unsigned QB     = Q_BITS;
   localparam int unsigned ADEPTH = NUM_PROCESSES * NUM_PAGES;
   localparam int unsigned TDEPTH = ADEPTH * NUM_PAGES;
   localparam int unsigned AAW    = $clog2(ADEPTH);
   localparam int unsigned TAW    = $clog2(TDEPTH);
   localparam int unsigned IW     = $clog2(NUM_PAGES);
   localparam int unsigned PIW    = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;

   st_type state_ff, state_in;

   logic [TAW-1:0] clr_ff, clr_in;
   logic           hv_ff [NUM_PROCESSES];
   logic [IW-1:0]  prev_ff [NUM_PROCESSES];

   logic [4:0]     proc_ff, page_ff;
   logic           item_hv_ff;
   logic [IW-1:0]  item_prev_ff;
   logic [CB-1:0]  den_ff;
   logic [IW-1:0]  cnt_ff;
   logic [TAW-1:0] row_base_ff;

   logic           rv_ff;
   logic [IW-1:0]  ri_ff;

   logic           pv_ff [QB];
   logic [CB-1:0]  pr_ff [QB];
   logic [QB-1:0]  pq_ff [QB];
   prob_kind_type  pk_ff [QB];
   logic [IW-1:0]  pi_ff [QB];
   logic [CB-1:0]  pr_in [QB];
   logic [QB-1:0]  pq_in [QB];

   logic           out_valid_ff;
   logic [4:0]     out_to_ff;
   logic [16:0]    out_prob_ff;
   logic           out_last_ff;

   logic           accept, in_range, adv;
   logic [AAW-1:0] acc_addr_req, acc_addr_prev;
   logic [TAW-1:0] trn_addr;
   logic           acc_we, trn_we, trn_re;
   logic [AAW-1:0] acc_waddr, acc_raddr;
   logic [TAW-1:0] trn_waddr, trn_raddr;
   logic [CB-1:0]  acc_wdata, trn_wdata, acc_rdata, trn_rdata;
   logic [CB-1:0]  acc_inc, trn_inc;
   prob_kind_type  kind0;

   assign in_range = (32'(req_process_id) < NUM_PROCESSES) && (32'(req_page) < NUM_PAGES);
   assign accept   = req_valid && !req_stall;
   assign adv      = !out_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   assign acc_addr_req  = AAW'(32'(req_process_id) * NUM_PAGES + 32'(req_page));
   assign acc_addr_prev = AAW'(32'(proc_ff) * NUM_PAGES + 32'(item_prev_ff));
   assign trn_addr      = TAW'(32'(acc_addr_prev) * NUM_PAGES + 32'(page_ff));

   assign acc_inc = (acc_rdata == {CB{1'b1}}) ? acc_rdata : acc_rdata + 1'b1;
   assign trn_inc = (trn_rdata == {CB{1'b1}}) ? trn_rdata : trn_rdata + 1'b1;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == TAW'(TDEPTH - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (accept && in_range) state_in = ST_ACC;
         ST_ACC:   state_in = ST_TRN;
         ST_TRN:   state_in = ST_ROW;
         ST_ROW:   if (adv && cnt_ff == IW'(NUM_PAGES - 1)) state_in = ST_DRAIN;
         ST_DRAIN: if (out_valid_ff && !rsp_stall && out_last_ff) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   // RAM port control.
   always_comb begin
      acc_we    = 1'b0;
      acc_waddr = AAW'(clr_ff);
      acc_wdata = '0;
      acc_raddr = acc_addr_req;
      trn_we    = 1'b0;
      trn_waddr = clr_ff;
      trn_wdata = '0;
      trn_raddr = trn_addr;
      trn_re    = 1'b1;
      clr_in    = clr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            trn_we = 1'b1;
            acc_we = (clr_ff < TAW'(ADEPTH));
         end
         ST_ACC: begin
            acc_we    = 1'b1;
            acc_waddr = AAW'(32'(proc_ff) * NUM_PAGES + 32'(page_ff));
            acc_wdata = acc_inc;
         end
         ST_TRN: begin
            trn_we    = item_hv_ff;
            trn_waddr = trn_addr;
            trn_wdata = trn_inc;
         end
         ST_ROW: begin
            trn_re    = adv;
            trn_raddr = row_base_ff + TAW'(cnt_ff);
         end
         ST_DRAIN: trn_re = adv;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         for (int i = 0; i < NUM_PROCESSES; i++) hv_ff[i] <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (accept && in_range) begin
            hv_ff[PIW'(req_process_id)] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && in_range) begin
         proc_ff      <= req_process_id;
         page_ff      <= req_page;
         item_hv_ff   <= hv_ff[PIW'(req_process_id)];
         item_prev_ff <= prev_ff[PIW'(req_process_id)];
         prev_ff[PIW'(req_process_id)] <= IW'(req_page);
         row_base_ff  <= TAW'(32'(acc_addr_req) * NUM_PAGES);
      end
      if (state_ff == ST_ACC) begin
         den_ff <= acc_inc;
      end
      if (state_ff == ST_TRN) begin
         cnt_ff <= '0;
      end else if (state_ff == ST_ROW && adv) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // One restoring division step per stage; the quotient only needs its
   // ordinary form when the count lies below the divisor.
   always_comb begin
      logic [CB-1:0] src_r;
      logic [QB-1:0] src_q;
      logic [CB:0]   sh;
      logic          ge;
      for (int j = 0; j < QB; j++) begin
         src_r = (j == 0) ? trn_rdata : pr_ff[(j == 0) ? 0 : j - 1];
         src_q = (j == 0) ? '0 : pq_ff[(j == 0) ? 0 : j - 1];
         sh    = {src_r, 1'b0};
         ge    = (sh >= {1'b0, den_ff});
         pr_in[j] = ge ? CB'(sh - {1'b0, den_ff}) : CB'(sh);
         pq_in[j] = {src_q[QB-2:0], ge};
      end
   end

   always_comb begin
      if (den_ff == '0) begin
         kind0 = PK_ZERO;
      end else if (trn_rdata >= den_ff) begin
         kind0 = PK_ONE;
      end else begin
         kind0 = PK_RATIO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int j = 0; j < QB; j++) pv_ff[j] <= 1'b0;
      end else if (adv) begin
         rv_ff        <= (state_ff == ST_ROW);
         pv_ff[0]     <= rv_ff;
         for (int j = 1; j < QB; j++) pv_ff[j] <= pv_ff[j-1];
         out_valid_ff <= pv_ff[QB-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ri_ff    <= cnt_ff;
         pr_ff[0] <= pr_in[0];
         pq_ff[0] <= pq_in[0];
         pk_ff[0] <= kind0;
         pi_ff[0] <= ri_ff;
         for (int j = 1; j < QB; j++) begin
            pr_ff[j] <= pr_in[j];
            pq_ff[j] <= pq_in[j];
            pk_ff[j] <= pk_ff[j-1];
            pi_ff[j] <= pi_ff[j-1];
         end
         out_to_ff   <= 5'(pi_ff[QB-1]);
         out_last_ff <= (pi_ff[QB-1] == IW'(NUM_PAGES - 1));
         unique case (pk_ff[QB-1])
            PK_ONE:   out_prob_ff <= 17'(1 << QB);
            PK_ZERO:  out_prob_ff <= '0;
            PK_RATIO: out_prob_ff <= {1'b0, pq_ff[QB-1]};
            default:  out_prob_ff <= '0;
         endcase
      end
   end

   ptpt_ram #(.WIDTH(CB), .DEPTH(ADEPTH)) u_acc_ram (
      .clock (clock),
      .we    (acc_we),
      .waddr (acc_waddr),
      .wdata (acc_wdata),
      .re    (1'b1),
      .raddr (acc_raddr),
      .rdata (acc_rdata)
   );

   ptpt_ram #(.WIDTH(CB), .DEPTH(TDEPTH)) u_trn_ram (
      .clock (clock),
      .we    (trn_we),
      .waddr (trn_waddr),
      .wdata (trn_wdata),
      .re    (trn_re),
      .raddr (trn_raddr),
      .rdata (trn_rdata)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_owner_process = proc_ff;
   assign rsp_from_page     = page_ff;
   assign rsp_to_page       = out_to_ff;
   assign rsp_probability   = out_prob_ff;
   assign rsp_last          = out_last_ff;

endmodule

// ----- tb/page_transition_probability_table_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// page_transition_probability_table_tb
// Drives page accesses into the transition table and checks every row entry
// against a behavioural model of the access and transition counters.
// ----------------------------------------------------------------------------

class ptpt_scoreboard;
   typedef struct packed {
      logic [4:0]  owner_process;
      logic [4:0]  from_page;
      logic [4:0]  to_page;
      logic [16:0] probability;
      logic        last;
   } row_entry_type;

   bit            hist_valid [32];
   bit [4:0]      prev_page [32];
   bit [15:0]     access_cnt [32][32];
   bit [15:0]     trans_cnt [32][32][32];
   row_entry_type pending_rows [$];
   int            error_count;

   function new();
      error_count = 0;
   endfunction

   function void note_access(bit [4:0] proc, bit [4:0] pg);
      bit [15:0]     den;
      bit [63:0]     q;
      row_entry_type e;
      if (access_cnt[proc][pg] != 16'hFFFF) access_cnt[proc][pg]++;
      if (hist_valid[proc] && trans_cnt[proc][prev_page[proc]][pg] != 16'hFFFF)
         trans_cnt[proc][prev_page[proc]][pg]++;
      prev_page[proc] = pg;
      hist_valid[proc] = 1'b1;
      den = access_cnt[proc][pg];
      for (int i = 0; i < 32; i++) begin
         if (den == 0) q = 0;
         else q = ({48'd0, trans_cnt[proc][pg][i]} << 16) / den;
         if (q > 65536) q = 65536;
         e.owner_process = proc;
         e.from_page = pg;
         e.to_page = i[4:0];
         e.probability = q[16:0];
         e.last = (i == 31);
         pending_rows.push_back(e);
      end
   endfunction

   function void check_entry(row_entry_type got);
      row_entry_type exp_e;
      if (pending_rows.size() == 0) begin
         $error("unexpected result transaction");
         error_count++;
         return;
      end
      exp_e = pending_rows.pop_front();
      if (got.owner_process != exp_e.owner_process) begin
         $error("owner_process exp %0d got %0d", exp_e.owner_process, got.owner_process);
         error_count++;
      end
      if (got.from_page != exp_e.from_page) begin
         $error("from_page exp %0d got %0d", exp_e.from_page, got.from_page);
         error_count++;
      end
      if (got.to_page != exp_e.to_page) begin
         $error("to_page exp %0d got %0d", exp_e.to_page, got.to_page);
         error_count++;
      end
      if (got.probability != exp_e.probability) begin
         $error("probability exp %0d got %0d", exp_e.probability, got.probability);
         error_count++;
      end
      if (got.last != exp_e.last) begin
         $error("last exp %0d got %0d", exp_e.last, got.last);
         error_count++;
      end
   endfunction
endclass

module page_transition_probability_table_tb;
   import ptpt_pkg::*;

   localparam int WATCHDOG_LIMIT = 200000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [4:0]  req_process_id;
   logic [4:0]  req_page;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [4:0]  rsp_owner_process;
   logic [4:0]  rsp_from_page;
   logic [4:0]  rsp_to_page;
   logic [16:0] rsp_probability;
   logic        rsp_last;

   ptpt_scoreboard sb;
   int  idle_cycles;
   int  rsp_wait;
   bit  hold_off;

   page_transition_probability_table u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_process_id(req_process_id), .req_page(req_page),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_owner_process(rsp_owner_process), .rsp_from_page(rsp_from_page),
      .rsp_to_page(rsp_to_page), .rsp_probability(rsp_probability),
      .rsp_last(rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_process_id = '0;
      req_page = '0;
      hold_off = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // Offer one access transaction and wait for it to be taken. Valid stays
   // high afterwards; it is dropped only for a gap or by wait_drained.
   task automatic send_access(input bit [4:0] proc, input bit [4:0] pg, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_process_id <= proc;
      req_page <= pg;
      do @(posedge clock); while (req_stall);
      sb.note_access(proc, pg);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_rows.size() != 0) @(posedge clock);
   endtask

   // Receiver: a random wait after each transaction, with one
   // long hold-off on request.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_entry({rsp_owner_process, rsp_from_page, rsp_to_page,
                         rsp_probability, rsp_last});
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait = 0;
      end else if (hold_off) begin
         rsp_stall <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         rsp_wait = $urandom_range(8);
         rsp_stall <= (rsp_wait != 0);
      end else if (rsp_wait > 0) begin
         rsp_wait = rsp_wait - 1;
         rsp_stall <= (rsp_wait != 0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Idle counter: reset whenever anything is accepted.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (!reset && idle_cycles > WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      bit [4:0] proc;
      bit [4:0] pg;
      @(negedge reset);
      @(posedge clock);
      // Directed: field extremes, a repeated page, and a long cycle of one process.
      send_access(5'd0, 5'd0, 0);
      send_access(5'd0, 5'd0, 0);
      send_access(5'd31, 5'd31, 0);
      send_access(5'd31, 5'd0, 1);
      send_access(5'd0, 5'd31, 0);
      send_access(5'd31, 5'd31, 0);
      for (int i = 0; i < 8; i++) send_access(5'd21, 5'(i % 3), 0);
      send_access(5'd10, 5'd21, 0);
      send_access(5'd21, 5'd10, 2);
      // The sender pauses until every expected row has arrived.
      wait_drained();
      // Long receiver hold-off while accesses keep being offered.
      fork
         begin
            hold_off = 1'b1;
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end
         begin
            for (int i = 0; i < 6; i++) send_access(5'(i), 5'(31 - i), 0);
            wait_drained();
         end
      join
      // Random: mostly a few processes walking small page sets so counts grow.
      for (int n = 0; n < 190; n++) begin
         if ($urandom_range(4) == 0) begin
            proc = 5'($urandom);
            pg = 5'($urandom);
         end else begin
            proc = 5'($urandom_range(3));
            pg = 5'($urandom_range(5));
         end
         send_access(proc, pg, ($urandom_range(3) == 0) ? 0 : $urandom_range(8));
      end
      wait_drained();
      repeat (100) @(posedge clock);
      if (sb.error_count == 0 && sb.pending_rows.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
